// File: rtl/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared constants, codes and types for the bounded deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdqs_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int RSP_FIELD_W = VALUE_WIDTH + POS_W + CNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_REPORT,
      S_BACK
   } state_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic rotate;
      logic load_tail;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/bdqs_cell.sv
// ----------------------------------------------------------------------------
// bdqs_cell
// One storage cell of the deque chain; shifts, rotates, loads or holds each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqs_cell (
   input  wire                                  clock,
   input  wire  bdqs_pkg::cell_ctrl_type        ctrl,
   input  wire  [bdqs_pkg::VALUE_WIDTH-1:0]     ins_value,
   input  wire  [bdqs_pkg::VALUE_WIDTH-1:0]     from_left,
   input  wire  [bdqs_pkg::VALUE_WIDTH-1:0]     from_right,
   input  wire  [bdqs_pkg::VALUE_WIDTH-1:0]     head_value,
   input  wire                                  is_tail,
   input  wire                                  is_next,
   output logic [bdqs_pkg::VALUE_WIDTH-1:0]     value
);

   logic [bdqs_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [bdqs_pkg::VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_right) begin
         value_in = from_left;
      end else if (ctrl.shift_left) begin
         value_in = from_right;
      end else if (ctrl.rotate) begin
         value_in = is_tail ? head_value : from_right;
      end else if (ctrl.load_tail && is_next) begin
         value_in = ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded deque held in a chain of cells, front in cell 0, with search.
// ----------------------------------------------------------------------------
// Inserts, front delete, empty/full/unused ops: result registered in the cycle after accept.
// Back delete: the chain rotates until the back element reaches cell 0, then pops it.
// Search: the chain rotates once per element, back to its order, then reports.
// One beat at a time; the next is taken in idle once the result register frees.
// Reset: occupancy, controller and output valid clear; cell contents are not cleared.
`default_nettype none

module bounded_deque_with_search (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [31:0]                         req_tdata,  // value_in
   input  wire  [bdqs_pkg::OP_W-1:0]           req_tuser,  // op
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [bdqs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // value_out, position, occupancy
   output logic [bdqs_pkg::STATUS_W-1:0]       rsp_tuser   // status
);

   localparam int VW = bdqs_pkg::VALUE_WIDTH;
   localparam int PW = bdqs_pkg::POS_W;
   localparam int CW = bdqs_pkg::CNT_W;

   bdqs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] step_ff, step_in;
   logic          found_ff, found_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [VW-1:0] key_ff, key_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bdqs_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                   rsp_value_ff, rsp_value_in;
   logic [PW-1:0]                   rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]                   rsp_occ_ff, rsp_occ_in;

   bdqs_pkg::cell_ctrl_type ctrl;
   logic [VW-1:0] cell_value [bdqs_pkg::DEPTH];
   logic [VW-1:0] req_value;
   logic          out_free;
   logic          accept;
   logic          is_full;
   logic          is_empty;

   assign req_value = req_tdata[VW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_full   = (count_ff == CW'(bdqs_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign accept    = req_tvalid && req_tready;

   genvar i;
   generate
      for (i = 0; i < bdqs_pkg::DEPTH; i++) begin : g_cell
         logic [VW-1:0] left_v;
         logic [VW-1:0] right_v;
         if (i == 0) begin : g_first
            assign left_v = req_value;
         end else begin : g_mid_l
            assign left_v = cell_value[i-1];
         end
         if (i == bdqs_pkg::DEPTH - 1) begin : g_last
            assign right_v = cell_value[i];
         end else begin : g_mid_r
            assign right_v = cell_value[i+1];
         end
         bdqs_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .ins_value  (req_value),
            .from_left  (left_v),
            .from_right (right_v),
            .head_value (cell_value[0]),
            .is_tail    (count_ff == CW'(i + 1)),
            .is_next    (count_ff == CW'(i)),
            .value      (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_occ_in    = rsp_occ_ff;
      ctrl          = '0;
      req_tready    = 1'b0;

      case (state_ff)
         bdqs_pkg::S_IDLE: begin
            req_tready = out_free;
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bdqs_pkg::STS_OK;
               rsp_value_in  = '0;
               rsp_pos_in    = '0;
               rsp_occ_in    = count_ff;
               case (req_tuser)
                  bdqs_pkg::OP_INS_FRONT, bdqs_pkg::OP_INS_BACK: begin
                     if (is_full) begin
                        rsp_status_in = bdqs_pkg::STS_FULL;
                     end else begin
                        ctrl.shift_right = (req_tuser == bdqs_pkg::OP_INS_FRONT);
                        ctrl.load_tail   = (req_tuser == bdqs_pkg::OP_INS_BACK);
                        count_in         = count_ff + CW'(1);
                        rsp_occ_in       = count_ff + CW'(1);
                     end
                  end
                  bdqs_pkg::OP_DEL_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = bdqs_pkg::STS_EMPTY;
                     end else begin
                        ctrl.shift_left = 1'b1;
                        rsp_value_in    = cell_value[0];
                        count_in        = count_ff - CW'(1);
                        rsp_occ_in      = count_ff - CW'(1);
                     end
                  end
                  bdqs_pkg::OP_DEL_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = bdqs_pkg::STS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        step_in      = PW'(count_ff - CW'(1));
                        state_in     = bdqs_pkg::S_BACK;
                     end
                  end
                  bdqs_pkg::OP_SEARCH: begin
                     if (is_empty) begin
                        rsp_status_in = bdqs_pkg::STS_NOTFOUND;
                     end else begin
                        rsp_valid_in = 1'b0;
                        key_in       = req_value;
                        step_in      = '0;
                        found_in     = 1'b0;
                        pos_in       = '0;
                        state_in     = bdqs_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bdqs_pkg::S_SEARCH: begin
            ctrl.rotate = 1'b1;
            if (!found_ff && cell_value[0] == key_ff) begin
               found_in = 1'b1;
               pos_in   = step_ff;
            end
            if (CW'(step_ff) == count_ff - CW'(1)) begin
               state_in = bdqs_pkg::S_REPORT;
            end else begin
               step_in = step_ff + PW'(1);
            end
         end
         bdqs_pkg::S_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? bdqs_pkg::STS_OK : bdqs_pkg::STS_NOTFOUND;
               rsp_value_in  = '0;
               rsp_pos_in    = found_ff ? pos_ff : '0;
               rsp_occ_in    = count_ff;
               state_in      = bdqs_pkg::S_IDLE;
            end
         end
         bdqs_pkg::S_BACK: begin
            if (step_ff != '0) begin
               ctrl.rotate = 1'b1;
               step_in     = step_ff - PW'(1);
            end else if (out_free) begin
               ctrl.shift_left = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = bdqs_pkg::STS_OK;
               rsp_value_in    = cell_value[0];
               rsp_pos_in      = '0;
               rsp_occ_in      = count_ff - CW'(1);
               count_in        = count_ff - CW'(1);
               state_in        = bdqs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bdqs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdqs_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = bdqs_pkg::RSP_DATA_W'({rsp_occ_ff, rsp_pos_ff, rsp_value_ff});

endmodule

`default_nettype wire

// File: rtl/bdqs_check.sv
// ----------------------------------------------------------------------------
// bdqs_check
// Port-level checks for the bounded deque with search, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqs_check (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [bdqs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire [bdqs_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int VW = bdqs_pkg::VALUE_WIDTH;
   localparam int PW = bdqs_pkg::POS_W;
   localparam int CW = bdqs_pkg::CNT_W;

   logic [CW-1:0] occ;
   logic [PW-1:0] pos;
   logic [VW-1:0] vout;

   assign vout = rsp_tdata[VW-1:0];
   assign pos  = rsp_tdata[VW+PW-1:VW];
   assign occ  = rsp_tdata[VW+PW+CW-1:VW+PW];

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bdqs_pkg::STS_FULL |-> occ == CW'(bdqs_pkg::DEPTH))
      else $error("full reported below capacity");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bdqs_pkg::STS_EMPTY |-> occ == '0 && vout == '0)
      else $error("empty reported with data");

   a_notfound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bdqs_pkg::STS_NOTFOUND |-> pos == '0 && vout == '0)
      else $error("not found with nonzero fields");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ <= CW'(bdqs_pkg::DEPTH))
      else $error("occupancy beyond depth");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

endmodule

bind bounded_deque_with_search bdqs_check u_bdqs_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: test/bounded_deque_with_search_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb
// Drives inserts, deletes and searches into the bounded deque and checks
// every response beat against a queue-based shadow of the deque or a typed
// row's expected fields. A short table of directed beats covers the empty
// store, the value extremes, first match among duplicates and the unused
// op codes. Random fill, drain and mixed phases then reach a full store.
// Both channels idle at random, with one stretch that runs without stalls.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdqs_pkg::*;

   localparam int ITEM_TARGET  = 650;
   localparam int IDLE_PCT     = 13;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
   localparam int NUM_ROWS     = 24;

   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_WIDTH-1:0] value_out;
      logic [POS_W-1:0]       position;
      logic [CNT_W-1:0]       occupancy;
   } deque_result_type;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [VALUE_WIDTH-1:0] value;
      logic                   typed;
      logic [STATUS_W-1:0]    status;
      logic [VALUE_WIDTH-1:0] value_out;
      logic [POS_W-1:0]       position;
      logic [CNT_W-1:0]       occupancy;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;   // value_in
   logic [OP_W-1:0]        req_tuser = '0;   // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // value_out, position, occupancy
   logic [STATUS_W-1:0]    rsp_tuser;        // status

   logic                   quiet = 1'b0;
   int                     error_count = 0;
   logic [VALUE_WIDTH-1:0] shadow_deque[$];
   deque_result_type       pending_results[$];

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{OP_DEL_FRONT, 32'h0000_0000, 1'b1, STS_EMPTY,    32'h0000_0000, 6'd0, 7'd0},
      '{OP_DEL_BACK,  32'h0000_0000, 1'b1, STS_EMPTY,    32'h0000_0000, 6'd0, 7'd0},
      '{OP_SEARCH,    32'h0000_0000, 1'b1, STS_NOTFOUND, 32'h0000_0000, 6'd0, 7'd0},
      '{OP_INS_BACK,  32'h7FFF_FFFF, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd1},
      '{OP_INS_FRONT, 32'h8000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd2},
      '{OP_INS_BACK,  32'h0000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd3},
      '{OP_INS_FRONT, 32'hFFFF_FFFF, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd4},
      '{OP_SEARCH,    32'h7FFF_FFFF, 1'b1, STS_OK,       32'h0000_0000, 6'd2, 7'd4},
      '{OP_SEARCH,    32'hFFFF_FFFF, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd4},
      '{OP_SEARCH,    32'h0000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd3, 7'd4},
      '{OP_SEARCH,    32'h0000_0001, 1'b1, STS_NOTFOUND, 32'h0000_0000, 6'd0, 7'd4},
      '{OP_INS_BACK,  32'h8000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd5},
      '{OP_SEARCH,    32'h8000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd1, 7'd5},
      '{OP_RSVD_5,    32'hFFFF_FFFF, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd5},
      '{OP_RSVD_6,    32'h0000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd5},
      '{OP_RSVD_7,    32'h1234_5678, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd5},
      '{OP_DEL_BACK,  32'h0000_0000, 1'b1, STS_OK,       32'h8000_0000, 6'd0, 7'd4},
      '{OP_DEL_FRONT, 32'hFFFF_FFFF, 1'b1, STS_OK,       32'hFFFF_FFFF, 6'd0, 7'd3},
      '{OP_DEL_FRONT, 32'h0000_0000, 1'b1, STS_OK,       32'h8000_0000, 6'd0, 7'd2},
      '{OP_DEL_BACK,  32'h0000_0000, 1'b1, STS_OK,       32'h0000_0000, 6'd0, 7'd1},
      '{OP_DEL_BACK,  32'h0000_0000, 1'b1, STS_OK,       32'h7FFF_FFFF, 6'd0, 7'd0},
      '{OP_DEL_FRONT, 32'h0000_0000, 1'b1, STS_EMPTY,    32'h0000_0000, 6'd0, 7'd0},
      '{OP_INS_FRONT, 32'h55AA_55AA, 1'b0, STS_OK,       32'h0000_0000, 6'd0, 7'd0},
      '{OP_SEARCH,    32'h55AA_55AA, 1'b0, STS_OK,       32'h0000_0000, 6'd0, 7'd0}
   };

   bounded_deque_with_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic deque_result_type apply_deque_op(input logic [OP_W-1:0] op,
                                                       input logic [VALUE_WIDTH-1:0] value);
      deque_result_type r;
      int               i;
      r = '0;
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (shadow_deque.size() >= DEPTH) r.status = STS_FULL;
            else if (op == OP_INS_FRONT) shadow_deque.push_front(value);
            else shadow_deque.push_back(value);
         end
         OP_DEL_FRONT, OP_DEL_BACK: begin
            if (shadow_deque.size() == 0) r.status = STS_EMPTY;
            else if (op == OP_DEL_FRONT) r.value_out = shadow_deque.pop_front();
            else r.value_out = shadow_deque.pop_back();
         end
         OP_SEARCH: begin
            r.status = STS_NOTFOUND;
            for (i = 0; i < shadow_deque.size(); i++) begin
               if (shadow_deque[i] == value) begin
                  r.status   = STS_OK;
                  r.position = POS_W'(i);
                  break;
               end
            end
         end
         default: ;
      endcase
      r.occupancy = CNT_W'(shadow_deque.size());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_beat();
      deque_result_type want;
      deque_result_type got;
      got.status    = rsp_tuser;
      got.value_out = rsp_tdata[VALUE_WIDTH-1:0];
      got.position  = rsp_tdata[VALUE_WIDTH +: POS_W];
      got.occupancy = rsp_tdata[VALUE_WIDTH + POS_W +: CNT_W];
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected beat", 32'(got.status), '0);
      end else begin
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
         if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
         if (got.position !== want.position)
            report_mismatch("position", 32'(got.position), 32'(want.position));
         if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // valid stays high from one beat to the next unless an idle cycle is taken
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_WIDTH-1:0] value,
                            input logic typed, input deque_result_type want);
      deque_result_type predicted;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_deque_op(op, value);
      pending_results.push_back(typed ? want : predicted);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom;
      if (r < 75) return VALUE_WIDTH'($urandom_range(7));
      case ($urandom_range(3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input phase_mode_type mode);
      int r;
      int ins_lim;
      int del_lim;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL:  begin ins_lim = 73; del_lim = 83; end
         MODE_DRAIN: begin ins_lim = 13; del_lim = 83; end
         default:    begin ins_lim = 38; del_lim = 72; end
      endcase
      if (r < 3) begin
         case ($urandom_range(2))
            0: return OP_RSVD_5;
            1: return OP_RSVD_6;
            default: return OP_RSVD_7;
         endcase
      end
      if (r < ins_lim) return $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
      if (r < del_lim) return $urandom_range(1) ? OP_DEL_FRONT : OP_DEL_BACK;
      return OP_SEARCH;
   endfunction

   initial begin
      deque_result_type       want;
      phase_mode_type         mode;
      logic [OP_W-1:0]        op;
      logic [VALUE_WIDTH-1:0] value;
      int                     phase_left;
      int                     sent;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         want.status    = directed_rows[k].status;
         want.value_out = directed_rows[k].value_out;
         want.position  = directed_rows[k].position;
         want.occupancy = directed_rows[k].occupancy;
         send_beat(directed_rows[k].op, directed_rows[k].value, directed_rows[k].typed, want);
      end

      mode       = MODE_FILL;
      phase_left = $urandom_range(140, 100);
      sent       = 0;
      while (sent < ITEM_TARGET) begin
         if (phase_left == 0) begin
            case (mode)
               MODE_FILL:  mode = MODE_DRAIN;
               MODE_DRAIN: mode = MODE_MIXED;
               default:    mode = MODE_FILL;
            endcase
            phase_left = $urandom_range(140, 80);
         end
         quiet <= (sent >= 250 && sent < 350);
         op = pick_op(mode);
         if (op == OP_SEARCH && shadow_deque.size() != 0 && $urandom_range(99) < 60)
            value = shadow_deque[$urandom_range(shadow_deque.size() - 1)];
         else
            value = pick_value();
         send_beat(op, value, 1'b0, '0);
         if (op <= OP_SEARCH) begin
            sent++;
            phase_left--;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS bounded_deque_with_search");
      else
         $display("FAIL bounded_deque_with_search");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL bounded_deque_with_search");
      $finish;
   end

endmodule

// File: sim.f
rtl/bdqs_pkg.sv
rtl/bdqs_cell.sv
rtl/bounded_deque_with_search.sv
rtl/bdqs_check.sv
test/bounded_deque_with_search_tb.sv
